@@ design/chb_pkg.sv @@
// Shared types, constants and quantizer functions for the color histogram block.
`default_nettype none

package chb_pkg;

    localparam int COMP_W   = 8;
    localparam int LVL_W    = 9;
    localparam int CNT_W    = 32;
    localparam int BIDX_W   = 12;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 27;
    localparam int OFF_W    = 11;
    localparam int NUM_COMP = 3;
    localparam int CFG_AW   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [CFG_AW-1:0] REG_QUANT_MODE   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SPLIT_MODE   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LEVELS_RED   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_LEVELS_GREEN = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LEVELS_BLUE  = 3'd4;

    localparam logic [LVL_W-1:0] LEVELS_RESET = 9'd3;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] comp;
        logic       bump_rd;
        logic       bump_wr;
        logic       bin_rd;
        logic       out_load;
        logic       clr_start;
        logic       clr_step;
    } chb_cmd_t;

    typedef struct packed {
        logic                split;
        logic [NUM_COMP-1:0] skip;
        logic                oor;
        logic                clr_last;
        logic                out_free;
    } chb_sts_t;

    function automatic logic [3:0] eff_bits(input logic [LVL_W-1:0] l);
        return (l > 9'd8) ? 4'd8 : l[3:0];
    endfunction

    function automatic logic [LVL_W-1:0] radix_of(input logic [LVL_W-1:0] l, input logic qm);
        return qm ? l : (LVL_W'(1) << eff_bits(l));
    endfunction

    function automatic logic [LVL_W-1:0] quantize(input logic [COMP_W-1:0] c,
                                                  input logic [LVL_W-1:0]  l,
                                                  input logic              qm);
        logic [COMP_W+LVL_W-1:0] prod;
        logic [LVL_W-1:0]        q;
        prod = (COMP_W+LVL_W)'(c) * (COMP_W+LVL_W)'(l);
        if (qm) begin
            q = prod[COMP_W+LVL_W-1:COMP_W];
            if (q >= l) begin
                q = l - 1'b1;
            end
        end else begin
            q = LVL_W'(c >> (4'd8 - eff_bits(l)));
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ design/chb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module chb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire  [WIDTH-1:0]          wr_data,
    input  wire                       rd_en,
    input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/chb_ctrl.sv @@
// Controller state machine: sequences quantize, index steps, bin updates, reads and clears.
`default_nettype none

module chb_ctrl #(
    parameter int COMPONENTS = 3
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    input  wire  [chb_pkg::OP_W-1:0] s_op,
    output logic                    s_tready,
    input  wire  chb_pkg::chb_sts_t sts,
    output chb_pkg::chb_cmd_t       cmd
);
    import chb_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_BWR  = 3'd4;
    localparam logic [2:0] S_RRD  = 3'd5;
    localparam logic [2:0] S_ROUT = 3'd6;

    localparam logic [1:0] LAST_COMP = 2'(COMPONENTS - 1);

    logic [2:0] state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic       last;

    assign last     = (comp_reg == LAST_COMP);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_op)
                        OP_ADD: begin
                            cmd.load   = 1'b1;
                            comp_next  = 2'd0;
                            state_next = S_STEP;
                        end
                        OP_READ: begin
                            cmd.load   = 1'b1;
                            state_next = S_RRD;
                        end
                        OP_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLR;
                        end
                        OP_NOP: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                cmd.step = 1'b1;
                if (sts.split) begin
                    if (!sts.skip[comp_reg]) begin
                        state_next = S_BRD;
                    end else if (last) begin
                        state_next = S_IDLE;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else if (last) begin
                    state_next = S_BRD;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            S_BRD: begin
                cmd.bump_rd = 1'b1;
                if (!sts.oor) begin
                    state_next = S_BWR;
                end else if (sts.split && !last) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_STEP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_BWR: begin
                cmd.bump_wr = 1'b1;
                if (sts.split && !last) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_STEP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RRD: begin
                cmd.bin_rd = 1'b1;
                state_next = S_ROUT;
            end
            S_ROUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            comp_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
        end
    end

endmodule

`default_nettype wire

@@ design/chb_dp.sv @@
// Datapath: configuration, quantizers, bin index arithmetic, histogram RAM and result register.
`default_nettype none

module chb_dp #(
    parameter int MAX_BINS = 4096
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire  [chb_pkg::CFG_AW-1:0] cfg_addr,
    input  wire  [chb_pkg::LVL_W-1:0]  cfg_wdata,
    input  wire  [chb_pkg::COMP_W-1:0] s_red,
    input  wire  [chb_pkg::COMP_W-1:0] s_green,
    input  wire  [chb_pkg::COMP_W-1:0] s_blue,
    input  wire  [chb_pkg::BIDX_W-1:0] s_bin_index,
    input  wire  chb_pkg::chb_cmd_t    cmd,
    output chb_pkg::chb_sts_t          sts,
    input  wire                        m_tready,
    output logic                       m_valid,
    output logic [chb_pkg::CNT_W-1:0]  m_count,
    output logic                       m_dropped
);
    import chb_pkg::*;

    localparam int AW = $clog2(MAX_BINS);

    logic                quant_mode_reg;
    logic                split_mode_reg;
    logic [LVL_W-1:0]    lvl_reg [NUM_COMP];
    logic [COMP_W-1:0]   comp_in [NUM_COMP];
    logic [LVL_W-1:0]    q_reg   [NUM_COMP];
    logic [BIDX_W-1:0]   bi_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OFF_W-1:0]    off_reg;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                dropped_reg;
    logic [AW-1:0]       clr_reg;
    logic                out_valid_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_dropped_reg;

    logic [LVL_W-1:0]       q_sel, lvl_sel, radix_sel;
    logic                   skip_sel;
    logic [IDX_W+LVL_W-1:0] mul;
    logic                   oor, bi_oor;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [CNT_W-1:0]       ram_wdata, ram_rdata;

    assign comp_in[0] = s_red;
    assign comp_in[1] = s_green;
    assign comp_in[2] = s_blue;

    assign q_sel     = q_reg[cmd.comp];
    assign lvl_sel   = lvl_reg[cmd.comp];
    assign skip_sel  = (lvl_sel == '0);
    assign radix_sel = radix_of(lvl_sel, quant_mode_reg);
    assign mul       = (IDX_W+LVL_W)'(idx_reg) * (IDX_W+LVL_W)'(radix_sel);
    assign idx_next  = mul[IDX_W-1:0] + IDX_W'(q_sel);
    assign addr_next = split_mode_reg ? (IDX_W'(off_reg) + IDX_W'(q_sel)) : idx_next;

    assign oor    = (addr_reg >= IDX_W'(MAX_BINS));
    assign bi_oor = (32'(bi_reg) >= 32'(MAX_BINS));

    assign sts.split    = split_mode_reg;
    assign sts.skip[0]  = (lvl_reg[0] == '0);
    assign sts.skip[1]  = (lvl_reg[1] == '0);
    assign sts.skip[2]  = (lvl_reg[2] == '0);
    assign sts.oor      = oor;
    assign sts.clr_last = (clr_reg == AW'(MAX_BINS - 1));
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_mode_reg <= 1'b0;
            split_mode_reg <= 1'b0;
            lvl_reg[0]     <= LEVELS_RESET;
            lvl_reg[1]     <= LEVELS_RESET;
            lvl_reg[2]     <= LEVELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_QUANT_MODE:   quant_mode_reg <= cfg_wdata[0];
                REG_SPLIT_MODE:   split_mode_reg <= cfg_wdata[0];
                REG_LEVELS_RED:   lvl_reg[0]     <= cfg_wdata;
                REG_LEVELS_GREEN: lvl_reg[1]     <= cfg_wdata;
                REG_LEVELS_BLUE:  lvl_reg[2]     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                q_reg[i] <= quantize(comp_in[i], lvl_reg[i], quant_mode_reg);
            end
            bi_reg   <= s_bin_index;
            idx_reg  <= '0;
            off_reg  <= '0;
            addr_reg <= '0;
        end else if (cmd.step && !skip_sel) begin
            addr_reg <= addr_next;
            if (split_mode_reg) begin
                off_reg <= off_reg + OFF_W'(radix_sel);
            end else begin
                idx_reg <= idx_next;
            end
        end
        if (cmd.out_load) begin
            out_count_reg   <= bi_oor ? '0 : ram_rdata;
            out_dropped_reg <= dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dropped_reg   <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_start) begin
                dropped_reg <= 1'b0;
                clr_reg     <= '0;
            end else begin
                if (cmd.bump_rd && oor) begin
                    dropped_reg <= 1'b1;
                end
                if (cmd.clr_step) begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = cmd.clr_step || cmd.bump_wr;
    assign ram_waddr = cmd.clr_step ? clr_reg : AW'(addr_reg);
    assign ram_wdata = cmd.clr_step ? '0
                     : ((ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1);
    assign ram_re    = (cmd.bump_rd && !oor) || (cmd.bin_rd && !bi_oor);
    assign ram_raddr = cmd.bin_rd ? AW'(bi_reg) : AW'(addr_reg);

    chb_ram #(
        .WIDTH(CNT_W),
        .DEPTH(MAX_BINS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign m_valid   = out_valid_reg;
    assign m_count   = out_count_reg;
    assign m_dropped = out_dropped_reg;

endmodule

`default_nettype wire

@@ design/color_histogram_binning_top.sv @@
// Top level of the quantized RGB color histogram: stream ports, config port, controller and datapath.
`default_nettype none

// Quantized RGB color histogram with MAX_BINS saturating 32-bit counters in one
// histogram RAM. One input beat is handled at a time; each count update is a
// read-modify-write on the single RAM read port, which sets the timing. Pixel add,
// combined mode: the components are quantized and stepped into one index, then its
// bin is read and written back, with no write when the index is out of range.
// Pixel add, split mode: each component with nonzero levels gets its own bin read
// and write, or a read only when out of range. A bin read may wait for the result
// slot, which holds one finished result while the next beats are taken. An unused
// opcode does no further work. Clear writes one zero per cycle with s_tready low;
// the sweep after reset clears the RAM the same way.
// Write configuration only while idle.

module color_histogram_binning_top #(
    parameter int MAX_BINS   = 4096,
    parameter int COMPONENTS = 3
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // red [7:0], green [15:8], blue [23:16], bin_index [35:24]
    input  wire  [chb_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode [1:0]
    input  wire  [chb_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // bin_count [31:0], dropped [32]
    output logic [chb_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire                           cfg_we,
    input  wire  [chb_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire  [chb_pkg::LVL_W-1:0]     cfg_wdata
);
    import chb_pkg::*;

    chb_cmd_t         cmd;
    chb_sts_t         sts;
    logic [CNT_W-1:0] count;
    logic             dropped;

    chb_ctrl #(
        .COMPONENTS(COMPONENTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_op    (s_tuser),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chb_dp #(
        .MAX_BINS(MAX_BINS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_red      (s_tdata[7:0]),
        .s_green    (s_tdata[15:8]),
        .s_blue     (s_tdata[23:16]),
        .s_bin_index(s_tdata[35:24]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_valid    (m_tvalid),
        .m_count    (count),
        .m_dropped  (dropped)
    );

    assign m_tdata = {(M_DATA_W - CNT_W - 1)'(0), dropped, count};

endmodule

`default_nettype wire

@@ design/chb_checker.sv @@
// Port-level checker for the color histogram top level, bound to every instance.
`default_nettype none

module chb_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [chb_pkg::OP_W-1:0]      s_tuser,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [chb_pkg::M_DATA_W-1:0]  m_tdata
);
    import chb_pkg::*;

    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken during the clearing sweep after reset");

    a_busy_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_ADD || s_tuser == OP_READ
                                  || s_tuser == OP_CLEAR)) |=> !s_tready)
        else $error("input taken in the cycle after an add, read or clear beat");

    a_nop_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_NOP) |=> s_tready)
        else $error("unused opcode left the block busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed or dropped");

endmodule

bind color_histogram_binning_top chb_checker u_chb_checker (.*);

`default_nettype wire
